/* rtl/utf8_string_validator_top_macros.svh */
// assertion macros for the utf8 string validator
// expects clk and rst_n in the scope of each use
`ifndef UTF8_STRING_VALIDATOR_TOP_MACROS_SVH
`define UTF8_STRING_VALIDATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define U8SV_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("u8sv assertion failed");
`define U8SV_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("u8sv forbidden condition");
`else
`define U8SV_ASSERT(label, prop)
`define U8SV_NEVER(label, cond)
`endif

`endif

/* rtl/utf8sv_pkg.sv */
// shared constants of the utf8 string validator
// no dependencies
package utf8sv_pkg;

    localparam int CP_W = 21;

    // sequence lengths, none when no multi-byte sequence is open
    localparam logic [2:0] SEQ_NONE  = 3'd0;
    localparam logic [2:0] SEQ_TWO   = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR  = 3'd4;

    // smallest codepoint each length may encode, and the legal ceiling
    localparam logic [CP_W-1:0] MIN_TWO    = 21'h00080;
    localparam logic [CP_W-1:0] MIN_THREE  = 21'h00800;
    localparam logic [CP_W-1:0] MIN_FOUR   = 21'h10000;
    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LOW   = 21'h0D800;
    localparam logic [CP_W-1:0] SURR_HIGH  = 21'h0DFFF;

endpackage

/* rtl/utf8sv_if.sv */
// valid/ready channels of the utf8 string validator
// standalone, no package needed
interface utf8sv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, data_byte, has_byte, last, input ready);
    modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

interface utf8sv_res_if;
    logic valid;
    logic ready;
    logic valid_res;

    modport source (output valid, valid_res, input ready);
    modport sink   (input valid, valid_res, output ready);
endinterface

/* rtl/utf8_string_validator_top.sv */
// utf8 string validator, top level
// depends on utf8sv_pkg, utf8sv_if.sv and utf8_string_validator_top_macros.svh
//
// usage
//   str carries one word per cycle while ready is high: data_byte with has_byte set, and last on
//   the final word of a string. a word with has_byte low is an end-only word
//   when last is set and a no-op otherwise
//   verdict carries one word per string: valid_res is 1 when the string was
//   well-formed utf-8 with no nul, no overlong form, no surrogate and no
//   codepoint above 0x10ffff, and no sequence was cut off by the end mark
//   the verdict is registered and visible in the cycle after the word marked
//   last is taken; throughput is one byte per cycle while str is ready, set by
//   the combinational decode that updates the sequence state on every accepted word
//   the verdict sits in an output register; str stays ready while that
//   register is empty or being drained, so a stalled receiver only stops
//   input once a verdict is waiting and not taken
//   reset clears the sequence state and empties the output register; after
//   the first error the rest of the string is skipped up to its end mark
`include "utf8_string_validator_top_macros.svh"

module utf8_string_validator_top (
    input  logic                clk,
    input  logic                rst_n,
    utf8sv_byte_if.sink         str,
    utf8sv_res_if.source        verdict
);
    import utf8sv_pkg::*;

    // sequence state
    logic [1:0]      pending_reg,  pending_next;
    logic [2:0]      seqlen_reg,   seqlen_next;
    logic [CP_W-1:0] cp_reg,       cp_next;
    logic            failed_reg,   failed_next;

    // verdict output register
    logic            out_valid_reg, out_valid_next;
    logic            out_res_reg,   out_res_next;

    logic            in_fire;
    logic            out_fire;
    logic [7:0]      b;
    logic [CP_W-1:0] cont_cp;
    logic [1:0]      cont_pending;
    logic            cp_bad;
    logic            str_failed;
    logic            str_pending;

    // input is blocked only while an untaken verdict is held
    assign str.ready     = !out_valid_reg || verdict.ready;
    assign in_fire       = str.valid && str.ready;
    assign out_fire      = out_valid_reg && verdict.ready;
    assign verdict.valid = out_valid_reg;
    assign verdict.valid_res = out_res_reg;

    assign b            = str.data_byte;
    assign cont_cp      = {cp_reg[CP_W-7:0], b[5:0]};
    assign cont_pending = pending_reg - 2'd1;

    // overlong, out of range or surrogate on a finished sequence
    always_comb
    begin
        cp_bad = (cont_cp > CP_MAX) || (cont_cp >= SURR_LOW && cont_cp <= SURR_HIGH);
        case (seqlen_reg)
            SEQ_TWO:   cp_bad = cp_bad || (cont_cp < MIN_TWO);
            SEQ_THREE: cp_bad = cp_bad || (cont_cp < MIN_THREE);
            SEQ_FOUR:  cp_bad = cp_bad || (cont_cp < MIN_FOUR);
            default:   cp_bad = cp_bad;
        endcase
    end

    // byte decode
    always_comb
    begin
        pending_next = pending_reg;
        seqlen_next  = seqlen_reg;
        cp_next      = cp_reg;
        failed_next  = failed_reg;

        if (in_fire && str.has_byte && !failed_reg)
        begin
            if (pending_reg == 2'd0)
            begin
                // lead byte
                case (b) inside
                    8'h00:
                        failed_next = 1'b1;
                    [8'h01:8'h7F]:
                        seqlen_next = SEQ_NONE;
                    [8'hC0:8'hDF]:
                    begin
                        seqlen_next  = SEQ_TWO;
                        pending_next = 2'd1;
                        cp_next      = {{(CP_W-5){1'b0}}, b[4:0]};
                    end
                    [8'hE0:8'hEF]:
                    begin
                        seqlen_next  = SEQ_THREE;
                        pending_next = 2'd2;
                        cp_next      = {{(CP_W-4){1'b0}}, b[3:0]};
                    end
                    [8'hF0:8'hF7]:
                    begin
                        seqlen_next  = SEQ_FOUR;
                        pending_next = 2'd3;
                        cp_next      = {{(CP_W-3){1'b0}}, b[2:0]};
                    end
                    default:
                        failed_next = 1'b1;
                endcase
            end
            else if (b[7:6] != 2'b10)
            begin
                failed_next = 1'b1;
            end
            else
            begin
                // continuation byte
                pending_next = cont_pending;
                cp_next      = cont_cp;
                if (cont_pending == 2'd0)
                begin
                    failed_next = cp_bad;
                    seqlen_next = SEQ_NONE;
                    cp_next     = '0;
                end
            end
        end

        str_failed  = failed_next;
        str_pending = (pending_next != 2'd0);

        // end mark: give the verdict, then start a fresh string
        if (in_fire && str.last)
        begin
            pending_next = 2'd0;
            seqlen_next  = SEQ_NONE;
            cp_next      = '0;
            failed_next  = 1'b0;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_fire;
        out_res_next   = out_res_reg;
        if (in_fire && str.last)
        begin
            out_valid_next = 1'b1;
            out_res_next   = !str_failed && !str_pending;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 2'd0;
            seqlen_reg    <= SEQ_NONE;
            cp_reg        <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            seqlen_reg    <= seqlen_next;
            cp_reg        <= cp_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    // an open sequence always has a length
    `U8SV_NEVER(a_pending_has_len, pending_reg != 2'd0 && seqlen_reg == SEQ_NONE)
    // an end mark leaves a clean state
    `U8SV_ASSERT(a_end_clears, (in_fire && str.last) |=> (pending_reg == 2'd0 && !failed_reg))
    // a taken verdict with no new end mark empties the output register
    `U8SV_ASSERT(a_drain, (out_fire && !(in_fire && str.last)) |=> !out_valid_reg)
    // an empty output register never blocks input
    `U8SV_ASSERT(a_ready_when_empty, !out_valid_reg |-> str.ready)

endmodule
